FILE: src/mht_pkg.sv
// Shared types, sizes and codes for the miss status holding table.
// No dependencies; every other file refers to this package by scoped names.
package mht_pkg;

  localparam int ROWS = 16;
  localparam int COLS = 16;
  localparam int ROW_W = $clog2(ROWS);
  localparam int COL_W = $clog2(COLS);
  localparam int LEN_W = $clog2(COLS + 1);
  localparam int USE_W = $clog2(ROWS + 1);
  localparam int ADDR_W = $clog2(ROWS * COLS);
  localparam int TIME_W = 48;
  localparam int ENTRY_W = TIME_W + 1;
  localparam int RESULT_LIMIT = 16;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_DRAIN  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISS     = 2'd1;
  localparam logic [1:0] ST_REJECTED = 2'd2;

  localparam logic [1:0] KIND_NONE    = 2'd0;
  localparam logic [1:0] KIND_FIRST   = 2'd1;
  localparam logic [1:0] KIND_DRAINED = 2'd2;

  typedef struct packed {
    logic             done;
    logic             hit;
    logic [ROW_W-1:0] hit_row;
    logic             free_ok;
    logic [ROW_W-1:0] free_row;
  } scan_res_t;

  function automatic logic [ADDR_W-1:0] entry_addr(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
    entry_addr = ADDR_W'(ADDR_W'(row) * ADDR_W'(COLS) + ADDR_W'(col));
  endfunction

endpackage

FILE: src/mht_entry_ram.sv
// Request entry memory: one write port and one registered read port.
// Depends on mht_pkg for its depth and entry width.
module mht_entry_ram (
  input  logic                              clk,
  input  logic                              we,
  input  logic [mht_pkg::ADDR_W-1:0]        waddr,
  input  logic [mht_pkg::ENTRY_W-1:0]       wdata,
  input  logic [mht_pkg::ADDR_W-1:0]        raddr,
  output logic [mht_pkg::ENTRY_W-1:0]       rdata
);

  logic [mht_pkg::ENTRY_W-1:0] mem [mht_pkg::ROWS * mht_pkg::COLS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: src/mht_scan.sv
// Row scanner: one shared tag comparator walks the rows, one per cycle,
// and finds the matching row and the lowest free row. Depends on mht_pkg.
module mht_scan (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [mht_pkg::TIME_W-1:0]        key,
  input  logic [mht_pkg::ROWS-1:0]          row_valid,
  input  logic [mht_pkg::TIME_W-1:0]        row_tag [mht_pkg::ROWS],
  output mht_pkg::scan_res_t                res
);

  logic                      busy_r;
  logic [mht_pkg::ROW_W-1:0] idx_r;
  mht_pkg::scan_res_t        res_r;
  logic                      match;

  assign match = row_valid[idx_r] && (row_tag[idx_r] == key);
  assign res = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r <= '0;
      res_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      idx_r <= '0;
      res_r <= '0;
    end else if (busy_r) begin
      if (match && !res_r.hit) begin
        res_r.hit <= 1'b1;
        res_r.hit_row <= idx_r;
      end
      if (!row_valid[idx_r] && !res_r.free_ok) begin
        res_r.free_ok <= 1'b1;
        res_r.free_row <= idx_r;
      end
      if (idx_r == mht_pkg::ROW_W'(mht_pkg::ROWS - 1)) begin
        busy_r <= 1'b0;
        res_r.done <= 1'b1;
      end else begin
        idx_r <= idx_r + 1'b1;
      end
    end else begin
      res_r.done <= 1'b0;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) res_r.done |-> !busy_r)
    else $error("scan done while still busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !start |=> busy_r || res_r.done)
    else $error("scan ended without done");
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(res_r.hit) |-> $past(busy_r))
    else $error("hit recorded outside a scan");

endmodule

FILE: src/miss_status_holding_table.sv
// Miss status holding table, top level.
// Uses mht_pkg, mht_scan (tag search) and mht_entry_ram (request entries).
//
// Usage: one input transaction on in_* carries an opcode (lookup, insert or
// drain), a block address and the request fields. The block answers on out_*
// with one or more result transactions; out_last marks the final one.
// A lookup, an insert, a rejected insert, a drain on a missing address and a
// drain that removes nothing give exactly one result. A drain gives one
// result per removed entry, at most sixteen, in queue order.
//
// Sequence: every transaction first runs a tag search in which one shared
// comparator visits the rows one per cycle (ROWS rows, 16 by default).
// The S_EXEC state then applies the update, and a single-result transaction
// shows its result in S_HOLD. A drain passes through S_POP (memory read),
// S_RD (output register) and S_HOLD (handshake) for each removed entry, and
// each result waits in S_HOLD until out_ready is high.
// in_ready is high only while the block is idle, so a new transaction is
// accepted only after the last result of the previous one has been taken.
//
// Reset (rst_n low, synchronous) empties the table: all rows invalid, counts
// and the full flag cleared. The entry memory is not cleared; entries are
// only read after they are written. When the receiver holds out_ready low,
// the result stays in the output register and the block waits.
module miss_status_holding_table (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         in_opcode,
  input  logic [mht_pkg::TIME_W-1:0]         in_block_address,
  input  logic [mht_pkg::TIME_W-1:0]         in_arrival_time,
  input  logic                               in_request_is_read,
  input  logic [4:0]                         in_drain_budget,
  input  logic                               in_head_already_served,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_address_present,
  output logic [1:0]                         out_status,
  output logic [1:0]                         out_entry_kind,
  output logic [mht_pkg::TIME_W-1:0]         out_entry_time,
  output logic                               out_entry_is_read,
  output logic                               out_was_full,
  output logic                               out_row_removed,
  output logic                               out_table_full,
  output logic                               out_last
);

  // Sequencer states.
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCAN = 6'b000010,
    S_EXEC = 6'b000100,
    S_POP  = 6'b001000,
    S_RD   = 6'b010000,
    S_HOLD = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // The accepted transaction.
  logic [1:0]                  op_r;
  logic [mht_pkg::TIME_W-1:0]  addr_r;
  logic [mht_pkg::TIME_W-1:0]  time_r;
  logic                        isrd_r;
  logic [4:0]                  budget_r;
  logic                        served_r;

  // Table state.
  logic [mht_pkg::ROWS-1:0]    valid_r;
  logic [mht_pkg::TIME_W-1:0]  tag_r [mht_pkg::ROWS];
  logic [mht_pkg::COL_W-1:0]   head_r [mht_pkg::ROWS];
  logic [mht_pkg::LEN_W-1:0]   len_r [mht_pkg::ROWS];
  logic [mht_pkg::USE_W-1:0]   use_r;
  logic [mht_pkg::LEN_W-1:0]   longest_r;
  logic                        full_r;

  // Drain progress.
  logic [mht_pkg::ROW_W-1:0]   row_r;
  logic [4:0]                  cnt_r;
  logic                        first_r;
  logic [1:0]                  kind_r;
  logic                        wasf_r;
  logic                        rem_r;

  // Output register.
  logic                        out_valid_r;
  logic                        o_present_r;
  logic [1:0]                  o_status_r;
  logic [1:0]                  o_kind_r;
  logic [mht_pkg::TIME_W-1:0]  o_time_r;
  logic                        o_isrd_r;
  logic                        o_wasf_r;
  logic                        o_rem_r;
  logic                        o_last_r;

  mht_pkg::scan_res_t          sres;
  logic                        in_acc;

  // Entry memory ports.
  logic                          ram_we;
  logic [mht_pkg::ADDR_W-1:0]    ram_waddr;
  logic [mht_pkg::ADDR_W-1:0]    ram_raddr;
  logic [mht_pkg::ENTRY_W-1:0]   ram_rdata;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc = in_valid && in_ready;

  mht_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_acc),
    .key       (addr_r),
    .row_valid (valid_r),
    .row_tag   (tag_r),
    .res       (sres)
  );

  // Row chosen for an insert: the matching row, or a newly allocated free one.
  logic                        ins_ok;
  logic [mht_pkg::ROW_W-1:0]   ins_row;
  logic [mht_pkg::COL_W-1:0]   ins_head;
  logic [mht_pkg::LEN_W-1:0]   ins_len;
  logic [mht_pkg::LEN_W:0]     ins_sum;
  logic [mht_pkg::COL_W-1:0]   ins_col;
  logic [mht_pkg::LEN_W-1:0]   ins_newlen;
  logic [mht_pkg::USE_W-1:0]   ins_use;

  always_comb begin
    ins_row = sres.hit ? sres.hit_row : sres.free_row;
    ins_ok = sres.hit ? (len_r[sres.hit_row] < mht_pkg::LEN_W'(mht_pkg::COLS))
                      : sres.free_ok;
    ins_head = sres.hit ? head_r[sres.hit_row] : '0;
    ins_len = sres.hit ? len_r[sres.hit_row] : '0;
    ins_sum = (mht_pkg::LEN_W + 1)'(ins_head) + (mht_pkg::LEN_W + 1)'(ins_len);
    if (ins_sum >= (mht_pkg::LEN_W + 1)'(mht_pkg::COLS)) begin
      ins_col = mht_pkg::COL_W'(ins_sum - (mht_pkg::LEN_W + 1)'(mht_pkg::COLS));
    end else begin
      ins_col = mht_pkg::COL_W'(ins_sum);
    end
    ins_newlen = ins_len + 1'b1;
    ins_use = sres.hit ? use_r : use_r + 1'b1;
  end

  // Drain plan: the number of pops is fixed up front so that the end-of-item
  // flags are known before the first result leaves.
  logic [7:0]                  dr_len;
  logic                        dr_hp;
  logic [7:0]                  dr_rest;
  logic [7:0]                  dr_rl;
  logic [7:0]                  dr_lim;
  logic [7:0]                  dr_k;
  logic [4:0]                  dr_n;
  logic                        dr_empty;
  logic                        dr_wasf0;

  always_comb begin
    dr_len = 8'(len_r[sres.hit_row]);
    dr_hp = !served_r && (dr_len != 8'd0);
    if (served_r) begin
      dr_rest = 8'(budget_r);
    end else begin
      dr_rest = (budget_r != 5'd0) ? 8'(budget_r - 5'd1) : 8'd0;
    end
    dr_rl = dr_len - 8'(dr_hp);
    dr_lim = 8'(mht_pkg::RESULT_LIMIT) - 8'(dr_hp);
    dr_k = dr_rest;
    if (dr_rl < dr_k) begin
      dr_k = dr_rl;
    end
    if (dr_lim < dr_k) begin
      dr_k = dr_lim;
    end
    dr_n = 5'(dr_k) + 5'(dr_hp);
    dr_empty = (dr_len == 8'(dr_n));
    dr_wasf0 = !served_r && (len_r[sres.hit_row] == longest_r) &&
               (longest_r >= mht_pkg::LEN_W'(mht_pkg::COLS));
  end

  assign ram_we = (state_r == S_EXEC) && (op_r == mht_pkg::OP_INSERT) && ins_ok;
  assign ram_waddr = mht_pkg::entry_addr(ins_row, ins_col);
  assign ram_raddr = mht_pkg::entry_addr(row_r, head_r[row_r]);

  mht_entry_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({isrd_r, time_r}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_SCAN;
      S_SCAN: if (sres.done) state_nxt = S_EXEC;
      S_EXEC: begin
        if (op_r == mht_pkg::OP_DRAIN && sres.hit && dr_n != 5'd0) begin
          state_nxt = S_POP;
        end else begin
          state_nxt = S_HOLD;
        end
      end
      S_POP: state_nxt = S_RD;
      S_RD: state_nxt = S_HOLD;
      S_HOLD: begin
        if (out_ready) begin
          state_nxt = (cnt_r != 5'd0) ? S_POP : S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control and table state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      use_r <= '0;
      longest_r <= '0;
      full_r <= 1'b0;
      cnt_r <= '0;
      first_r <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < mht_pkg::ROWS; i++) begin
        head_r[i] <= '0;
        len_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_EXEC: begin
          // A single-result transaction shows its result right after this cycle.
          out_valid_r <= (state_nxt == S_HOLD);
          if (op_r == mht_pkg::OP_INSERT && ins_ok) begin
            if (!sres.hit) begin
              valid_r[ins_row] <= 1'b1;
              head_r[ins_row] <= '0;
              use_r <= ins_use;
            end
            len_r[ins_row] <= ins_newlen;
            if (ins_use >= mht_pkg::USE_W'(mht_pkg::ROWS)) begin
              full_r <= 1'b1;
            end else if (ins_newlen > longest_r) begin
              longest_r <= ins_newlen;
              if (ins_newlen == mht_pkg::LEN_W'(mht_pkg::COLS)) begin
                full_r <= 1'b1;
              end
            end
          end else if (op_r == mht_pkg::OP_DRAIN && sres.hit) begin
            if (dr_wasf0) begin
              longest_r <= '0;
            end
            // The flag clears when the full-length row is drained, or when a
            // row of a completely used table is freed.
            if (dr_wasf0 || (dr_empty && use_r >= mht_pkg::USE_W'(mht_pkg::ROWS))) begin
              full_r <= 1'b0;
            end
            if (dr_empty) begin
              if (use_r != '0) begin
                use_r <= use_r - 1'b1;
              end
              valid_r[sres.hit_row] <= 1'b0;
            end
            cnt_r <= dr_n;
            first_r <= dr_hp;
          end
        end
        S_POP: begin
          if (head_r[row_r] == mht_pkg::COL_W'(mht_pkg::COLS - 1)) begin
            head_r[row_r] <= '0;
          end else begin
            head_r[row_r] <= head_r[row_r] + 1'b1;
          end
          len_r[row_r] <= len_r[row_r] - 1'b1;
          cnt_r <= cnt_r - 1'b1;
          first_r <= 1'b0;
        end
        S_RD: out_valid_r <= 1'b1;
        S_HOLD: if (out_ready) out_valid_r <= 1'b0;
        S_IDLE, S_SCAN: ;
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r <= in_opcode;
      addr_r <= in_block_address;
      time_r <= in_arrival_time;
      isrd_r <= in_request_is_read;
      budget_r <= in_drain_budget;
      served_r <= in_head_already_served;
    end
    if (state_r == S_EXEC) begin
      if (!ram_we) begin
        tag_r[ins_row] <= tag_r[ins_row];
      end else if (!sres.hit) begin
        tag_r[ins_row] <= addr_r;
      end
      row_r <= sres.hit_row;
      wasf_r <= (op_r == mht_pkg::OP_DRAIN) && sres.hit &&
                (dr_wasf0 || (dr_empty && use_r >= mht_pkg::USE_W'(mht_pkg::ROWS)));
      rem_r <= (op_r == mht_pkg::OP_DRAIN) && sres.hit && dr_empty;
      // Single-result transaction: fill the output register here.
      o_present_r <= sres.hit;
      o_kind_r <= mht_pkg::KIND_NONE;
      o_time_r <= '0;
      o_isrd_r <= 1'b0;
      o_last_r <= 1'b1;
      o_wasf_r <= (op_r == mht_pkg::OP_DRAIN) && sres.hit &&
                  (dr_wasf0 || (dr_empty && use_r >= mht_pkg::USE_W'(mht_pkg::ROWS)));
      o_rem_r <= (op_r == mht_pkg::OP_DRAIN) && sres.hit && dr_empty;
      if (op_r == mht_pkg::OP_INSERT && !ins_ok) begin
        o_status_r <= mht_pkg::ST_REJECTED;
      end else if (op_r == mht_pkg::OP_DRAIN && !sres.hit) begin
        o_status_r <= mht_pkg::ST_MISS;
      end else begin
        o_status_r <= mht_pkg::ST_OK;
      end
    end
    if (state_r == S_POP) begin
      kind_r <= first_r ? mht_pkg::KIND_FIRST : mht_pkg::KIND_DRAINED;
    end
    if (state_r == S_RD) begin
      o_present_r <= 1'b1;
      o_status_r <= mht_pkg::ST_OK;
      o_kind_r <= kind_r;
      o_time_r <= ram_rdata[mht_pkg::TIME_W-1:0];
      o_isrd_r <= ram_rdata[mht_pkg::TIME_W];
      o_wasf_r <= wasf_r;
      o_rem_r <= rem_r;
      o_last_r <= (cnt_r == 5'd0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_address_present = o_present_r;
  assign out_status = o_status_r;
  assign out_entry_kind = o_kind_r;
  assign out_entry_time = o_time_r;
  assign out_entry_is_read = o_isrd_r;
  assign out_was_full = o_wasf_r;
  assign out_row_removed = o_rem_r;
  // The full flag only changes in the update cycle, before any result is
  // shown, so every result of a transaction carries its end value.
  assign out_table_full = full_r;
  assign out_last = o_last_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    use_r <= mht_pkg::USE_W'(mht_pkg::ROWS))
    else $error("row count above table size");
  assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("sequencer state not one-hot");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_HOLD)
    else $error("result shown outside the hold state");
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_POP |-> len_r[row_r] != '0)
    else $error("pop from an empty row");

endmodule
